@@ rtl/core/btff_pkg.sv @@
// btff_pkg: shared constants, field widths and types of the boundary tag heap allocator
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package btff_pkg;

	localparam int DEF_MAX_HEAP_BYTES = 4096;
	localparam int HEAP_RESET_BYTES   = 4096;
	localparam int MIN_HEAP_BYTES     = 8;
	localparam int TAG_BYTES          = 2;
	localparam int PAIR_BYTES         = 2 * TAG_BYTES;
	localparam int MIN_REMAINDER      = 1 + 2 * TAG_BYTES;
	localparam int LEFT_TAG_OFFSET    = 3 * TAG_BYTES;

	localparam int ACTION_W  = 2;
	localparam int REQ_W     = 13;
	localparam int ADDR_W    = 12;
	localparam int BCOUNT_W  = 11;
	localparam int LFREE_W   = 13;
	localparam int HEAP_CFG_W = 13;
	localparam int TAG_SIZE_W = 15;
	localparam int KONST_W   = 3;

	localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INFO  = 2'd2;

	typedef struct packed {
		logic               sub;
		logic [KONST_W-1:0] k;
	} alu_ctrl_t;

endpackage

@@ rtl/core/btff_if.sv @@
// btff request and response channels: valid/ready handshake plus payload
// depends on btff_pkg for field widths
`timescale 1ns / 1ps

interface btff_req_if;
	import btff_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [REQ_W-1:0]    request_size;
	logic [ADDR_W-1:0]   address;
	modport source (output valid, action, request_size, address, input ready);
	modport sink (input valid, action, request_size, address, output ready);
endinterface

interface btff_rsp_if;
	import btff_pkg::*;
	logic                valid;
	logic                ready;
	logic                ok;
	logic [ADDR_W-1:0]   payload_address;
	logic [BCOUNT_W-1:0] block_count;
	logic [LFREE_W-1:0]  largest_free;
	modport source (output valid, ok, payload_address, block_count, largest_free, input ready);
	modport sink (input valid, ok, payload_address, block_count, largest_free, output ready);
endinterface

@@ rtl/core/btff_alu.sv @@
// btff_alu: shared add/subtract unit with a small constant term and sign flag
// depends on btff_pkg for alu_ctrl_t
`timescale 1ns / 1ps

module btff_alu #(
	parameter int W = 17
) (
	input  btff_pkg::alu_ctrl_t ctrl,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	output logic [W-1:0]        res,
	output logic                neg
);
	import btff_pkg::*;

	always_comb begin
		if (ctrl.sub) begin
			res = a - b - W'(ctrl.k);
		end else begin
			res = a + b + W'(ctrl.k);
		end
		neg = res[W-1];
	end

endmodule

@@ rtl/core/boundary_tag_first_fit_allocator_unit.sv @@
// boundary tag first-fit allocator: one request at a time, walked by a sequencer
// allocate walks the blocks to the first free fit, splitting it when the rest is large
// enough, and is refused early when the heap lacks room; free walks to the target block
// and merges it with free neighbours; info walks every block. One shared adder and a
// byte-wide heap store set the pace. Reset: counters clear and the single free block is
// rebuilt before the first request is taken; every heap_size write repeats that rebuild
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_unit #(
	parameter int MAX_HEAP_BYTES = btff_pkg::DEF_MAX_HEAP_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [btff_pkg::HEAP_CFG_W-1:0] cfg_wdata,
	btff_req_if.sink                        req,
	btff_rsp_if.source                      rsp
);
	import btff_pkg::*;

	localparam int HW = $clog2(MAX_HEAP_BYTES + 1);
	localparam int AW = $clog2(MAX_HEAP_BYTES);
	localparam int BW = $clog2(MAX_HEAP_BYTES / PAIR_BYTES + 1);
	localparam int AL = ((HW > TAG_SIZE_W) ? HW : TAG_SIZE_W) + 2;
	localparam int HEAP_RST = (HEAP_RESET_BYTES < MAX_HEAP_BYTES) ?
		HEAP_RESET_BYTES : MAX_HEAP_BYTES;
	localparam int NS = 38;

	typedef enum logic [NS-1:0] {
		ST_IDLE   = NS'(1) << 0,
		ST_INIT0  = NS'(1) << 1,
		ST_INIT1  = NS'(1) << 2,
		ST_RD0    = NS'(1) << 3,
		ST_RD1    = NS'(1) << 4,
		ST_RD2    = NS'(1) << 5,
		ST_WR0    = NS'(1) << 6,
		ST_WR1    = NS'(1) << 7,
		ST_WR2    = NS'(1) << 8,
		ST_WR3    = NS'(1) << 9,
		ST_ADV    = NS'(1) << 10,
		ST_DONE   = NS'(1) << 11,
		ST_A_SP1  = NS'(1) << 12,
		ST_A_SP2  = NS'(1) << 13,
		ST_A_SP3  = NS'(1) << 14,
		ST_A_WALK = NS'(1) << 15,
		ST_A_TEST = NS'(1) << 16,
		ST_A_REM  = NS'(1) << 17,
		ST_A_W1   = NS'(1) << 18,
		ST_A_W2   = NS'(1) << 19,
		ST_A_W3   = NS'(1) << 20,
		ST_A_W4   = NS'(1) << 21,
		ST_A_CNT  = NS'(1) << 22,
		ST_A_PAD  = NS'(1) << 23,
		ST_F_CHK  = NS'(1) << 24,
		ST_F_WALK = NS'(1) << 25,
		ST_F_TEST = NS'(1) << 26,
		ST_F_R0   = NS'(1) << 27,
		ST_F_R1   = NS'(1) << 28,
		ST_F_R2   = NS'(1) << 29,
		ST_F_R3   = NS'(1) << 30,
		ST_F_L0   = NS'(1) << 31,
		ST_F_L1   = NS'(1) << 32,
		ST_F_L2   = NS'(1) << 33,
		ST_F_L3   = NS'(1) << 34,
		ST_F_FIN  = NS'(1) << 35,
		ST_I_WALK = NS'(1) << 36,
		ST_I_TEST = NS'(1) << 37
	} state_t;

	state_t state_q, rd_ret_q, wr_ret_q;

	logic                  init_pend_q;
	logic [HW-1:0]         heap_q;
	logic [BW-1:0]         used_q;
	logic [HW-1:0]         up_q;
	logic [ACTION_W-1:0]   act_q;
	logic [REQ_W-1:0]      req_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [HW-1:0]         pos_q, tgt_q, rd_a_q, wb_from_q, wb_foot_q;
	logic [7:0]            lo_q;
	logic [TAG_SIZE_W-1:0] tsz_q, c_q, take_q, cur_q, ls_q, wb_size_q, largest_q;
	logic                  tfree_q, wb_free_q;
	logic [AL-1:0]         acc_q;
	logic                  ok_r_q;
	logic [ADDR_W-1:0]     paddr_r_q;

	logic                  out_valid_q, out_ok_q;
	logic [ADDR_W-1:0]     out_paddr_q;
	logic [BCOUNT_W-1:0]   out_bc_q;
	logic [LFREE_W-1:0]    out_lf_q;

	logic [7:0]            mem_q [MAX_HEAP_BYTES];
	logic [7:0]            mem_rd_q;
	logic                  mem_we;
	logic [HW-1:0]         mem_wa, mem_ra;
	logic [7:0]            mem_wd;

	alu_ctrl_t             alu_ctrl;
	logic [AL-1:0]         alu_a, alu_b, alu_res;
	logic                  alu_neg;

	logic                  req_fire, out_load;
	logic [HW-1:0]         cfg_clamped;

	btff_alu #(.W(AL)) u_alu (
		.ctrl(alu_ctrl),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.neg (alu_neg)
	);

	assign req.ready       = (state_q == ST_IDLE) && !init_pend_q;
	assign req_fire        = req.valid && req.ready;
	assign out_load        = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.payload_address = out_paddr_q;
	assign rsp.block_count = out_bc_q;
	assign rsp.largest_free = out_lf_q;

	always_comb begin
		if (int'(cfg_wdata) < MIN_HEAP_BYTES) begin
			cfg_clamped = HW'(MIN_HEAP_BYTES);
		end else if (int'(cfg_wdata) > MAX_HEAP_BYTES) begin
			cfg_clamped = HW'(MAX_HEAP_BYTES);
		end else begin
			cfg_clamped = HW'(cfg_wdata);
		end
	end

	// heap byte store
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wb_from_q;
		mem_wd = wb_size_q[7:0];
		mem_ra = (state_q == ST_RD1) ? (rd_a_q + HW'(1)) : rd_a_q;
		unique case (state_q)
			ST_WR0: begin
				mem_we = 1'b1;
			end
			ST_WR1: begin
				mem_we = 1'b1;
				mem_wa = wb_from_q + HW'(1);
				mem_wd = {wb_free_q, wb_size_q[14:8]};
			end
			ST_WR2: begin
				mem_we = 1'b1;
				mem_wa = wb_foot_q;
			end
			ST_WR3: begin
				mem_we = 1'b1;
				mem_wa = wb_foot_q + HW'(1);
				mem_wd = {wb_free_q, wb_size_q[14:8]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa[AW-1:0]] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_ra[AW-1:0]];
	end

	// operand selection for the shared adder
	always_comb begin
		alu_ctrl = '0;
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			ST_INIT0: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(PAIR_BYTES)};
				alu_a    = AL'(heap_q);
			end
			ST_INIT1: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(TAG_BYTES)};
				alu_a    = AL'(heap_q);
			end
			ST_A_SP1: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = AL'(heap_q);
				alu_b        = AL'(up_q);
			end
			ST_A_SP2: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = acc_q;
				alu_b        = AL'(used_q) << 2;
			end
			ST_A_SP3: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = acc_q;
				alu_b        = AL'(req_q);
			end
			ST_A_WALK, ST_F_WALK, ST_F_R1, ST_I_WALK: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = AL'(pos_q);
				alu_b        = AL'(heap_q);
			end
			ST_A_TEST: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = AL'(tsz_q);
				alu_b        = AL'(req_q);
			end
			ST_A_REM: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(MIN_REMAINDER)};
				alu_a    = AL'(c_q);
				alu_b    = AL'(req_q);
			end
			ST_A_W1: begin
				alu_ctrl.k = KONST_W'(TAG_BYTES);
				alu_a      = AL'(pos_q);
				alu_b      = AL'(take_q);
			end
			ST_A_W2: begin
				alu_ctrl.k = KONST_W'(PAIR_BYTES);
				alu_a      = AL'(pos_q);
				alu_b      = AL'(take_q);
			end
			ST_A_W3: begin
				alu_ctrl.k = KONST_W'(TAG_BYTES);
				alu_a      = AL'(pos_q);
				alu_b      = AL'(c_q);
			end
			ST_A_W4: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(PAIR_BYTES)};
				alu_a    = AL'(c_q);
				alu_b    = AL'(take_q);
			end
			ST_A_CNT: begin
				alu_a = AL'(up_q);
				alu_b = AL'(take_q);
			end
			ST_A_PAD: begin
				alu_ctrl.k = KONST_W'(TAG_BYTES);
				alu_a      = AL'(pos_q);
			end
			ST_ADV: begin
				alu_ctrl.k = KONST_W'(PAIR_BYTES);
				alu_a      = AL'(pos_q);
				alu_b      = AL'(tsz_q);
			end
			ST_F_CHK: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(TAG_BYTES)};
				alu_a    = AL'(addr_q);
			end
			ST_F_TEST: begin
				alu_ctrl.k = KONST_W'(TAG_BYTES);
				alu_a      = AL'(tgt_q);
				alu_b      = AL'(tsz_q);
			end
			ST_F_R0: begin
				alu_ctrl.k = KONST_W'(PAIR_BYTES);
				alu_a      = AL'(tgt_q);
				alu_b      = AL'(c_q);
			end
			ST_F_R2: begin
				alu_ctrl.k = KONST_W'(PAIR_BYTES);
				alu_a      = AL'(c_q);
				alu_b      = AL'(tsz_q);
			end
			ST_F_R3, ST_F_L3: begin
				alu_ctrl.k = KONST_W'(TAG_BYTES);
				alu_a      = AL'(tgt_q);
				alu_b      = AL'(cur_q);
			end
			ST_F_L0: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(PAIR_BYTES)};
				alu_a    = AL'(addr_q);
			end
			ST_F_L1: begin
				alu_ctrl = '{sub: 1'b1, k: KONST_W'(LEFT_TAG_OFFSET)};
				alu_a    = AL'(addr_q);
				alu_b    = AL'(tsz_q);
			end
			ST_F_L2: begin
				alu_ctrl.k = KONST_W'(PAIR_BYTES);
				alu_a      = AL'(cur_q);
				alu_b      = AL'(ls_q);
			end
			ST_F_FIN: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = AL'(up_q);
				alu_b        = AL'(c_q);
			end
			ST_I_TEST: begin
				alu_ctrl.sub = 1'b1;
				alu_a        = AL'(largest_q);
				alu_b        = AL'(tsz_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_pend_q <= 1'b1;
			heap_q      <= HW'(HEAP_RST);
			used_q      <= '0;
			up_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && out_valid_q && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (init_pend_q) begin
						init_pend_q <= 1'b0;
						wb_from_q   <= '0;
						wb_free_q   <= 1'b1;
						state_q     <= ST_INIT0;
					end else if (req_fire) begin
						act_q     <= req.action;
						req_q     <= req.request_size;
						addr_q    <= req.address;
						ok_r_q    <= 1'b0;
						paddr_r_q <= '0;
						largest_q <= '0;
						pos_q     <= '0;
						unique case (req.action)
							ACT_ALLOC: state_q <= ST_A_SP1;
							ACT_FREE:  state_q <= ST_F_CHK;
							ACT_INFO:  state_q <= ST_I_WALK;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_INIT0: begin
					wb_size_q <= TAG_SIZE_W'(alu_res);
					state_q   <= ST_INIT1;
				end
				ST_INIT1: begin
					wb_foot_q <= HW'(alu_res);
					wr_ret_q  <= ST_IDLE;
					state_q   <= ST_WR0;
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					lo_q    <= mem_rd_q;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					tsz_q   <= {mem_rd_q[6:0], lo_q};
					tfree_q <= mem_rd_q[7];
					state_q <= rd_ret_q;
				end
				ST_WR0: state_q <= ST_WR1;
				ST_WR1: state_q <= ST_WR2;
				ST_WR2: state_q <= ST_WR3;
				ST_WR3: state_q <= wr_ret_q;
				ST_ADV: begin
					pos_q <= HW'(alu_res);
					unique case (act_q)
						ACT_ALLOC: state_q <= ST_A_WALK;
						ACT_FREE:  state_q <= ST_F_WALK;
						default:   state_q <= ST_I_WALK;
					endcase
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= ok_r_q;
						out_paddr_q <= paddr_r_q;
						out_bc_q    <= BCOUNT_W'(used_q);
						out_lf_q    <= LFREE_W'(largest_q);
						state_q     <= ST_IDLE;
					end
				end
				ST_A_SP1: begin
					acc_q   <= alu_res;
					state_q <= ST_A_SP2;
				end
				ST_A_SP2: begin
					acc_q   <= alu_res;
					state_q <= ST_A_SP3;
				end
				ST_A_SP3: begin
					state_q <= alu_neg ? ST_DONE : ST_A_WALK;
				end
				ST_A_WALK: begin
					if (!alu_neg) begin
						state_q <= ST_DONE;
					end else begin
						rd_a_q   <= pos_q;
						rd_ret_q <= ST_A_TEST;
						state_q  <= ST_RD0;
					end
				end
				ST_A_TEST: begin
					if (tfree_q && !alu_neg) begin
						c_q     <= tsz_q;
						state_q <= ST_A_REM;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_A_REM: begin
					take_q  <= alu_neg ? c_q : TAG_SIZE_W'(req_q);
					state_q <= ST_A_W1;
				end
				ST_A_W1: begin
					wb_from_q <= pos_q;
					wb_foot_q <= HW'(alu_res);
					wb_size_q <= take_q;
					wb_free_q <= 1'b0;
					wr_ret_q  <= ST_A_W2;
					state_q   <= ST_WR0;
				end
				ST_A_W2: begin
					wb_from_q <= HW'(alu_res);
					state_q   <= (c_q == take_q) ? ST_A_CNT : ST_A_W3;
				end
				ST_A_W3: begin
					wb_foot_q <= HW'(alu_res);
					state_q   <= ST_A_W4;
				end
				ST_A_W4: begin
					wb_size_q <= TAG_SIZE_W'(alu_res);
					wb_free_q <= 1'b1;
					wr_ret_q  <= ST_A_CNT;
					state_q   <= ST_WR0;
				end
				ST_A_CNT: begin
					up_q    <= HW'(alu_res);
					used_q  <= used_q + BW'(1);
					state_q <= ST_A_PAD;
				end
				ST_A_PAD: begin
					paddr_r_q <= ADDR_W'(alu_res);
					ok_r_q    <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_F_CHK: begin
					tgt_q   <= HW'(alu_res);
					state_q <= alu_neg ? ST_DONE : ST_F_WALK;
				end
				ST_F_WALK: begin
					if (!alu_neg) begin
						state_q <= ST_DONE;
					end else if (pos_q == tgt_q) begin
						rd_a_q   <= tgt_q;
						rd_ret_q <= ST_F_TEST;
						state_q  <= ST_RD0;
					end else begin
						rd_a_q   <= pos_q;
						rd_ret_q <= ST_ADV;
						state_q  <= ST_RD0;
					end
				end
				ST_F_TEST: begin
					if (tfree_q) begin
						state_q <= ST_DONE;
					end else begin
						c_q       <= tsz_q;
						wb_from_q <= tgt_q;
						wb_foot_q <= HW'(alu_res);
						wb_size_q <= tsz_q;
						wb_free_q <= 1'b1;
						wr_ret_q  <= ST_F_R0;
						state_q   <= ST_WR0;
					end
				end
				ST_F_R0: begin
					pos_q   <= HW'(alu_res);
					cur_q   <= c_q;
					state_q <= ST_F_R1;
				end
				ST_F_R1: begin
					if (alu_neg) begin
						rd_a_q   <= pos_q;
						rd_ret_q <= ST_F_R2;
						state_q  <= ST_RD0;
					end else begin
						state_q <= ST_F_L0;
					end
				end
				ST_F_R2: begin
					if (tfree_q) begin
						cur_q   <= TAG_SIZE_W'(alu_res);
						state_q <= ST_F_R3;
					end else begin
						state_q <= ST_F_L0;
					end
				end
				ST_F_R3: begin
					wb_from_q <= tgt_q;
					wb_foot_q <= HW'(alu_res);
					wb_size_q <= cur_q;
					wb_free_q <= 1'b1;
					wr_ret_q  <= ST_F_L0;
					state_q   <= ST_WR0;
				end
				ST_F_L0: begin
					if (alu_neg) begin
						state_q <= ST_F_FIN;
					end else begin
						rd_a_q   <= HW'(alu_res);
						rd_ret_q <= ST_F_L1;
						state_q  <= ST_RD0;
					end
				end
				ST_F_L1: begin
					ls_q <= tsz_q;
					if (alu_neg) begin
						state_q <= ST_F_FIN;
					end else begin
						pos_q    <= HW'(alu_res);
						rd_a_q   <= HW'(alu_res);
						rd_ret_q <= ST_F_L2;
						state_q  <= ST_RD0;
					end
				end
				ST_F_L2: begin
					if (tfree_q) begin
						wb_size_q <= TAG_SIZE_W'(alu_res);
						state_q   <= ST_F_L3;
					end else begin
						state_q <= ST_F_FIN;
					end
				end
				ST_F_L3: begin
					wb_from_q <= pos_q;
					wb_foot_q <= HW'(alu_res);
					wb_free_q <= 1'b1;
					wr_ret_q  <= ST_F_FIN;
					state_q   <= ST_WR0;
				end
				ST_F_FIN: begin
					up_q <= alu_neg ? '0 : HW'(alu_res);
					if (used_q != '0) begin
						used_q <= used_q - BW'(1);
					end
					ok_r_q  <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_I_WALK: begin
					if (!alu_neg) begin
						ok_r_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rd_a_q   <= pos_q;
						rd_ret_q <= ST_I_TEST;
						state_q  <= ST_RD0;
					end
				end
				ST_I_TEST: begin
					if (tfree_q && alu_neg) begin
						largest_q <= tsz_q;
					end
					state_q <= ST_ADV;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				heap_q      <= cfg_clamped;
				used_q      <= '0;
				up_q        <= '0;
				init_pend_q <= 1'b1;
			end
		end
	end

endmodule

@@ sim/btff_checker.sv @@
// btff_checker: watches the request, response and register channels of the allocator,
// keeps its own copy of the heap and compares every response with the expected one
// depends on btff_pkg and the channel interfaces in btff_if
`timescale 1ns / 1ps

module btff_checker
	import btff_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [HEAP_CFG_W-1:0] cfg_wdata,
	btff_req_if                   req,
	btff_rsp_if                   rsp,
	output int                    fails,
	output int                    pending
);

	typedef struct packed {
		logic                ok;
		logic [ADDR_W-1:0]   payload_address;
		logic [BCOUNT_W-1:0] block_count;
		logic [LFREE_W-1:0]  largest_free;
	} outcome_t;

	logic [7:0] heap_mem [DEF_MAX_HEAP_BYTES];
	int         heap_len;
	int         live_blocks;
	int         live_bytes;
	outcome_t   outcome_q [$];
	int         mismatches;

	function automatic int rd_byte(int a);
		return (a < DEF_MAX_HEAP_BYTES) ? int'(heap_mem[a]) : 0;
	endfunction

	function automatic void wr_byte(int a, int v);
		if (a < DEF_MAX_HEAP_BYTES)
			heap_mem[a] = v[7:0];
	endfunction

	function automatic int tag_len(int a);
		return rd_byte(a) | ((rd_byte(a + 1) & 'h7f) << 8);
	endfunction

	function automatic bit tag_is_free(int a);
		return (rd_byte(a + 1) & 'h80) != 0;
	endfunction

	function automatic void write_tags(int from, int upto, bit is_free);
		int sz;
		int hi;
		sz = (upto - from - PAIR_BYTES) & 'h7fff;
		hi = (sz >> 8) | (is_free ? 'h80 : 0);
		wr_byte(from, sz);
		wr_byte(from + 1, hi);
		wr_byte(upto - 2, sz);
		wr_byte(upto - 1, hi);
	endfunction

	function automatic void join_blocks(int s1, int s2);
		if (tag_is_free(s1) && tag_is_free(s2))
			write_tags(s1, s2 + tag_len(s2) + PAIR_BYTES, 1'b1);
	endfunction

	function automatic void rebuild_heap();
		write_tags(0, heap_len, 1'b1);
		live_blocks = 0;
		live_bytes = 0;
	endfunction

	function automatic outcome_t predict_outcome(logic [ACTION_W-1:0] act,
			logic [REQ_W-1:0] rsize, logic [ADDR_W-1:0] addr);
		outcome_t o;
		int i, want, room, old, take, after, target, c, rgt, ls, best;
		bit hit;
		o = '0;
		want = int'(rsize);
		best = 0;
		hit = 1'b0;
		if (act == ACT_ALLOC) begin
			room = heap_len - live_bytes - PAIR_BYTES * live_blocks;
			if (room >= want) begin
				for (i = 0; i < heap_len; i += tag_len(i) + PAIR_BYTES) begin
					if (tag_is_free(i) && tag_len(i) >= want) begin
						hit = 1'b1;
						break;
					end
				end
				if (hit) begin
					old = tag_len(i);
					take = (old - want < MIN_REMAINDER) ? old : want;
					write_tags(i, i + take + PAIR_BYTES, 1'b0);
					live_blocks++;
					live_bytes += take;
					after = i + take + PAIR_BYTES;
					if (after < heap_len && old != take)
						write_tags(after, i + old + PAIR_BYTES, 1'b1);
					o.ok = 1'b1;
					o.payload_address = ADDR_W'(i + TAG_BYTES);
				end
			end
		end else if (act == ACT_FREE) begin
			if (int'(addr) >= TAG_BYTES) begin
				target = int'(addr) - TAG_BYTES;
				for (i = 0; i < heap_len; i += tag_len(i) + PAIR_BYTES) begin
					if (i == target) begin
						hit = 1'b1;
						break;
					end
				end
				if (hit && !tag_is_free(target)) begin
					c = tag_len(target);
					rgt = int'(addr) + c + TAG_BYTES;
					write_tags(target, rgt, 1'b1);
					if (rgt < heap_len)
						join_blocks(target, rgt);
					if (int'(addr) >= PAIR_BYTES) begin
						ls = tag_len(int'(addr) - PAIR_BYTES);
						if (int'(addr) >= ls + LEFT_TAG_OFFSET)
							join_blocks(int'(addr) - ls - LEFT_TAG_OFFSET, target);
					end
					if (live_blocks > 0)
						live_blocks--;
					live_bytes = (live_bytes >= c) ? live_bytes - c : 0;
					o.ok = 1'b1;
				end
			end
		end else if (act == ACT_INFO) begin
			for (i = 0; i < heap_len; i += tag_len(i) + PAIR_BYTES) begin
				if (tag_is_free(i) && tag_len(i) > best)
					best = tag_len(i);
			end
			o.ok = 1'b1;
			o.largest_free = LFREE_W'(best);
		end
		o.block_count = BCOUNT_W'(live_blocks);
		return o;
	endfunction

	assign pending = outcome_q.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t want_o;
		outcome_t got_o;
		int v;
		if (!arst_n) begin
			foreach (heap_mem[k])
				heap_mem[k] = 8'h00;
			heap_len = HEAP_RESET_BYTES;
			rebuild_heap();
			outcome_q.delete();
			fails = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				v = int'(cfg_wdata);
				if (v < MIN_HEAP_BYTES)
					v = MIN_HEAP_BYTES;
				if (v > DEF_MAX_HEAP_BYTES)
					v = DEF_MAX_HEAP_BYTES;
				heap_len = v;
				rebuild_heap();
			end
			if (rsp.valid && rsp.ready) begin
				got_o = {rsp.ok, rsp.payload_address, rsp.block_count, rsp.largest_free};
				if (outcome_q.size() == 0) begin
					fails++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response ok=%0b addr=%0d count=%0d largest=%0d",
							got_o.ok, got_o.payload_address, got_o.block_count,
							got_o.largest_free);
				end else begin
					want_o = outcome_q.pop_front();
					if (got_o !== want_o) begin
						fails++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected ok=%0b addr=%0d count=%0d largest=%0d, got ok=%0b addr=%0d count=%0d largest=%0d",
								want_o.ok, want_o.payload_address, want_o.block_count,
								want_o.largest_free, got_o.ok, got_o.payload_address,
								got_o.block_count, got_o.largest_free);
					end
				end
			end
			if (req.valid && req.ready)
				outcome_q.push_back(predict_outcome(req.action, req.request_size, req.address));
		end
	end

endmodule

@@ sim/tb_boundary_tag_first_fit_allocator_unit.sv @@
// tb_boundary_tag_first_fit_allocator_unit: drives requests and heap_size writes into the
// allocator with random idling on both channels and gives the verdict
// depends on btff_pkg, btff_if, the allocator and btff_checker
`timescale 1ns / 1ps

module tb_boundary_tag_first_fit_allocator_unit;
	import btff_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_BAD = 2'd3;
	localparam int STALL_LIMIT = 60000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [HEAP_CFG_W-1:0] cfg_wdata;
	int                    fails;
	int                    pending;
	int                    tx_idle;
	int                    rx_idle;
	int                    quiet_cycles;
	logic [ACTION_W-1:0]   sent_q [$];
	logic [ADDR_W-1:0]     live_q [$];
	logic [ADDR_W-1:0]     last_freed;

	btff_req_if req ();
	btff_rsp_if rsp ();

	boundary_tag_first_fit_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	btff_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rx_idle);
	end

	// live payload addresses, learned from allocate responses
	always @(posedge clk) begin
		logic [ACTION_W-1:0] act;
		if (arst_n && rsp.valid && rsp.ready && sent_q.size() > 0) begin
			act = sent_q.pop_front();
			if (act == ACT_ALLOC && rsp.ok)
				live_q.push_back(rsp.payload_address);
		end
		if (arst_n && req.valid && req.ready)
			sent_q.push_back(req.action);
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("boundary_tag_first_fit_allocator_unit regression: fail");
			$finish;
		end
	end

	task automatic send_request(logic [ACTION_W-1:0] act, logic [REQ_W-1:0] rsize,
			logic [ADDR_W-1:0] addr);
		if ($urandom_range(99) < tx_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < tx_idle)
				@(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.request_size <= rsize;
		req.address <= addr;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (sent_q.size() > 0 || pending > 0)
			@(negedge clk);
	endtask

	task automatic write_heap_size(logic [HEAP_CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		live_q.delete();
		@(negedge clk);
	endtask

	task automatic free_live();
		int k;
		if (live_q.size() == 0) begin
			send_request(ACT_INFO, REQ_W'($urandom), ADDR_W'($urandom));
		end else begin
			k = $urandom_range(live_q.size() - 1);
			last_freed = live_q[k];
			live_q.delete(k);
			send_request(ACT_FREE, REQ_W'($urandom), last_freed);
		end
	endtask

	task automatic random_request(int heap_bytes);
		int r;
		logic [REQ_W-1:0] rsize;
		r = $urandom_range(99);
		if (r < 45) begin
			if ($urandom_range(19) == 0)
				rsize = REQ_W'($urandom);
			else if ($urandom_range(9) == 0)
				rsize = REQ_W'($urandom_range(heap_bytes));
			else
				rsize = REQ_W'($urandom_range(48));
			send_request(ACT_ALLOC, rsize, ADDR_W'($urandom));
		end else if (r < 80) begin
			free_live();
		end else if (r < 85) begin
			send_request(ACT_FREE, REQ_W'($urandom), last_freed);
		end else if (r < 90) begin
			send_request(ACT_FREE, REQ_W'($urandom), ADDR_W'($urandom));
		end else if (r < 97) begin
			send_request(ACT_INFO, REQ_W'($urandom), ADDR_W'($urandom));
		end else begin
			send_request(ACT_BAD, REQ_W'($urandom), ADDR_W'($urandom));
		end
	endtask

	initial begin
		int sizes [8];
		int hb;
		sizes = '{4096, 64, 8191, 0, 300, 1000, 8, 4096};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.action = ACT_ALLOC;
		req.request_size = '0;
		req.address = '0;
		rsp.ready = 1'b0;
		tx_idle = 27;
		rx_idle = 68;
		last_freed = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset heap
		send_request(ACT_INFO, '0, '0);
		send_request(ACT_FREE, '0, 12'd0);
		send_request(ACT_FREE, '0, 12'd1);
		send_request(ACT_FREE, '0, 12'd4095);
		send_request(ACT_ALLOC, 13'd8191, '0);
		send_request(ACT_ALLOC, 13'd4096, '0);
		send_request(ACT_ALLOC, 13'd0, '0);
		send_request(ACT_ALLOC, 13'd10, '0);
		send_request(ACT_ALLOC, 13'd20, '0);
		send_request(ACT_BAD, 13'h1fff, 12'hfff);
		send_request(ACT_FREE, '0, 12'd7);
		send_request(ACT_FREE, '0, 12'd6);
		send_request(ACT_FREE, '0, 12'd6);
		send_request(ACT_FREE, '0, 12'd2);
		send_request(ACT_INFO, '0, '0);
		send_request(ACT_ALLOC, 13'd4088, '0);
		send_request(ACT_INFO, '0, '0);
		send_request(ACT_ALLOC, 13'd0, '0);
		send_request(ACT_FREE, '0, 12'd2);
		send_request(ACT_ALLOC, 13'd4092, '0);
		send_request(ACT_INFO, '0, '0);
		send_request(ACT_FREE, '0, 12'd2);

		for (int p = 0; p < 8; p++) begin
			if (p > 0)
				write_heap_size(HEAP_CFG_W'(sizes[p]));
			hb = sizes[p] < MIN_HEAP_BYTES ? MIN_HEAP_BYTES :
				(sizes[p] > DEF_MAX_HEAP_BYTES ? DEF_MAX_HEAP_BYTES : sizes[p]);
			if (p == 3) begin
				tx_idle = 68;
				rx_idle = 27;
			end else if (p == 6) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			for (int n = 0; n < 190; n++) begin
				random_request(hb);
				if (p == 4 && n == 90)
					drain();
			end
		end

		req.valid <= 1'b0;
		@(negedge clk);
		while (sent_q.size() > 0 || pending > 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("boundary_tag_first_fit_allocator_unit regression: pass");
		else
			$display("boundary_tag_first_fit_allocator_unit regression: fail");
		$finish;
	end

endmodule
